>>> src/mlft_pkg.sv
// Shared types, constants and field widths of the MPLS label forwarding table.
package mlft_pkg;

    localparam int LABEL_W = 20;
    localparam int IFACE_W = 4;
    localparam int COLOR_W = 16;
    localparam int OPCNT_W = 2;
    localparam int OPCODES_W = 6;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_OPS_DEF = 3;
    localparam logic [LABEL_W-1:0] LABEL_MAX = '1;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_INSTALL = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_LOAD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    // Stored contents of one table entry.
    typedef struct packed {
        logic [LABEL_W-1:0]   in_label;
        logic [IFACE_W-1:0]   in_iface;
        logic [IFACE_W-1:0]   out_iface;
        logic [COLOR_W-1:0]   color;
        logic [OPCNT_W-1:0]   op_count;
        logic [OPCODES_W-1:0] op_codes;
        logic [LABEL_W-1:0]   op0_label;
        logic [LABEL_W-1:0]   op1_label;
        logic [LABEL_W-1:0]   op2_label;
    } entry_t;

    typedef struct packed {
        logic [IFACE_W-1:0]   in_iface;
        logic                 match_any_iface;
        logic [LABEL_W-1:0]   in_label;
    } key_t;

    typedef struct packed {
        logic [COLOR_W-1:0]   color;
        logic [OPCNT_W-1:0]   op_count;
        logic [OPCODES_W-1:0] op_codes;
        logic [LABEL_W-1:0]   op0_label;
        logic [LABEL_W-1:0]   op1_label;
        logic [LABEL_W-1:0]   op2_label;
        logic [IFACE_W-1:0]   out_iface;
    } data_t;

endpackage

>>> src/mlft_if.sv
// Valid/ready channel interfaces for commands and results.
interface mlft_cmd_if;
    import mlft_pkg::*;
    logic valid;
    logic ready;
    logic [1:0]           command;
    logic [IFACE_W-1:0]   in_iface;
    logic                 match_any_iface;
    logic [LABEL_W-1:0]   in_label;
    logic                 allocate_label;
    logic [IFACE_W-1:0]   out_iface;
    logic [COLOR_W-1:0]   color;
    logic [OPCNT_W-1:0]   op_count;
    logic [OPCODES_W-1:0] op_codes;
    logic [LABEL_W-1:0]   op0_label;
    logic [LABEL_W-1:0]   op1_label;
    logic [LABEL_W-1:0]   op2_label;
    modport source (output valid, command, in_iface, match_any_iface, in_label,
        allocate_label, out_iface, color, op_count, op_codes, op0_label, op1_label,
        op2_label, input ready);
    modport sink (input valid, command, in_iface, match_any_iface, in_label,
        allocate_label, out_iface, color, op_count, op_codes, op0_label, op1_label,
        op2_label, output ready);
endinterface

interface mlft_rsp_if;
    import mlft_pkg::*;
    logic valid;
    logic ready;
    logic [1:0]           status;
    logic [LABEL_W-1:0]   result_label;
    logic [IFACE_W-1:0]   found_out_iface;
    logic [COLOR_W-1:0]   found_color;
    logic [OPCNT_W-1:0]   found_op_count;
    logic [OPCODES_W-1:0] found_op_codes;
    logic [LABEL_W-1:0]   found_op0_label;
    logic [LABEL_W-1:0]   found_op1_label;
    logic [LABEL_W-1:0]   found_op2_label;
    modport source (output valid, status, result_label, found_out_iface, found_color,
        found_op_count, found_op_codes, found_op0_label, found_op1_label,
        found_op2_label, input ready);
    modport sink (input valid, status, result_label, found_out_iface, found_color,
        found_op_count, found_op_codes, found_op0_label, found_op1_label,
        found_op2_label, output ready);
endinterface

>>> src/mlft_cell.sv
// One table cell: holds an entry, compares it with the key, loads or shifts.
module mlft_cell
    import mlft_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  key_t   key,
    input  logic   write_en,
    input  entry_t write_entry,
    input  logic   shift_en,
    input  logic   upper_valid,
    input  entry_t upper_entry,
    output logic   valid,
    output entry_t entry,
    output logic   hit_label,
    output logic   hit_lookup
);

    logic   valid_reg;
    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (write_en)
        begin
            valid_reg <= 1'b1;
        end
        else if (shift_en)
        begin
            valid_reg <= upper_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            entry_reg <= write_entry;
        end
        else if (shift_en)
        begin
            entry_reg <= upper_entry;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign hit_label = valid_reg && (entry_reg.in_label == key.in_label);
    assign hit_lookup = hit_label
        && (key.match_any_iface || (entry_reg.in_iface == key.in_iface));

endmodule

>>> src/mlft_ctrl.sv
// Sequencer: latches a command, resolves matches over the cell row, drives updates.
module mlft_ctrl
    import mlft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_OPS = MAX_OPS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    mlft_cmd_if.sink               cmd,
    mlft_rsp_if.source             rsp,
    output key_t                   key,
    output entry_t                 write_entry,
    input  logic [TABLE_DEPTH-1:0] cell_valid,
    input  logic [TABLE_DEPTH-1:0] hit_label,
    input  logic [TABLE_DEPTH-1:0] hit_lookup,
    input  entry_t                 cell_entry [TABLE_DEPTH],
    output logic [TABLE_DEPTH-1:0] write_en,
    output logic [TABLE_DEPTH-1:0] shift_en
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RESP} state_t;

    state_t             state_reg;
    cmd_t               cmd_reg;
    logic               alloc_reg;
    key_t               key_reg;
    entry_t             ent_reg;
    logic [LABEL_W-1:0] highest_reg;
    logic [LABEL_W-1:0] highest_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [LABEL_W-1:0] rlabel_reg;
    logic [LABEL_W-1:0] rlabel_next;
    data_t              found_reg;
    data_t              found_next;

    // Row-wide priority resolution over the cells.
    logic               any_label;
    logic               any_lookup;
    logic [IDX_W-1:0]   label_idx;
    logic [IDX_W-1:0]   lookup_idx;
    logic               full;
    logic [IDX_W-1:0]   free_idx;
    logic [LABEL_W-1:0] next_label;

    always_comb
    begin
        any_label = 1'b0;
        any_lookup = 1'b0;
        label_idx = '0;
        lookup_idx = '0;
        full = 1'b1;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (hit_label[i])
            begin
                any_label = 1'b1;
                label_idx = IDX_W'(i);
            end
            if (hit_lookup[i])
            begin
                any_lookup = 1'b1;
                lookup_idx = IDX_W'(i);
            end
            if (!cell_valid[i])
            begin
                full = 1'b0;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign next_label = highest_reg + LABEL_W'(1);
    assign key = key_reg;

    always_comb
    begin
        write_entry = ent_reg;
        write_en = '0;
        shift_en = '0;
        if (cmd_reg == CMD_INSTALL && alloc_reg)
        begin
            write_entry.in_label = next_label;
        end
        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg)
                CMD_LOOKUP:
                begin
                end
                CMD_INSTALL:
                begin
                    if (alloc_reg)
                    begin
                        if (highest_reg != LABEL_MAX && !full)
                        begin
                            write_en[free_idx] = 1'b1;
                        end
                    end
                    else if (any_label)
                    begin
                        write_en[label_idx] = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (any_label)
                    begin
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            shift_en[i] = (IDX_W'(i) >= label_idx);
                        end
                    end
                end
                CMD_LOAD:
                begin
                    if (!full)
                    begin
                        write_en[free_idx] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Response contents and the new highest label for the command in flight.
    always_comb
    begin
        status_next = ST_OK;
        rlabel_next = key_reg.in_label;
        found_next = '0;
        highest_next = highest_reg;
        unique case (cmd_reg)
            CMD_LOOKUP:
            begin
                if (any_lookup)
                begin
                    found_next.out_iface = cell_entry[lookup_idx].out_iface;
                    found_next.color = cell_entry[lookup_idx].color;
                    found_next.op_count = cell_entry[lookup_idx].op_count;
                    found_next.op_codes = cell_entry[lookup_idx].op_codes;
                    found_next.op0_label = cell_entry[lookup_idx].op0_label;
                    found_next.op1_label = cell_entry[lookup_idx].op1_label;
                    found_next.op2_label = cell_entry[lookup_idx].op2_label;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_INSTALL:
            begin
                if (alloc_reg)
                begin
                    if (highest_reg == LABEL_MAX)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        highest_next = next_label;
                        rlabel_next = next_label;
                    end
                end
                else if (!any_label)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_REMOVE:
            begin
                if (!any_label)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            CMD_LOAD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (key_reg.in_label > highest_reg)
                begin
                    highest_next = key_reg.in_label;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Clamp the operation list to the configured number of operations.
    function automatic entry_t pack_entry(
        input logic [IFACE_W-1:0] ii, input logic [LABEL_W-1:0] lab,
        input logic [IFACE_W-1:0] oi, input logic [COLOR_W-1:0] col,
        input logic [OPCNT_W-1:0] cnt, input logic [OPCODES_W-1:0] codes,
        input logic [LABEL_W-1:0] l0, input logic [LABEL_W-1:0] l1,
        input logic [LABEL_W-1:0] l2);
        entry_t e;
        e.in_label = lab;
        e.in_iface = ii;
        e.out_iface = oi;
        e.color = col;
        e.op_count = (cnt > OPCNT_W'(MAX_OPS)) ? OPCNT_W'(MAX_OPS) : cnt;
        e.op_codes = codes;
        e.op0_label = l0;
        e.op1_label = l1;
        e.op2_label = l2;
        if (MAX_OPS < 3)
        begin
            e.op_codes[5:4] = 2'b00;
            e.op2_label = '0;
        end
        if (MAX_OPS < 2)
        begin
            e.op_codes[3:2] = 2'b00;
            e.op1_label = '0;
        end
        return e;
    endfunction

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.status = status_reg;
    assign rsp.result_label = rlabel_reg;
    assign rsp.found_out_iface = found_reg.out_iface;
    assign rsp.found_color = found_reg.color;
    assign rsp.found_op_count = found_reg.op_count;
    assign rsp.found_op_codes = found_reg.op_codes;
    assign rsp.found_op0_label = found_reg.op0_label;
    assign rsp.found_op1_label = found_reg.op1_label;
    assign rsp.found_op2_label = found_reg.op2_label;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            highest_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        cmd_reg <= cmd_t'(cmd.command);
                        alloc_reg <= cmd.allocate_label;
                        key_reg.in_iface <= cmd.in_iface;
                        key_reg.match_any_iface <= cmd.match_any_iface;
                        key_reg.in_label <= cmd.in_label;
                        ent_reg <= pack_entry(cmd.in_iface, cmd.in_label, cmd.out_iface,
                            cmd.color, cmd.op_count, cmd.op_codes, cmd.op0_label,
                            cmd.op1_label, cmd.op2_label);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    status_reg <= status_next;
                    rlabel_reg <= rlabel_next;
                    found_reg <= found_next;
                    highest_reg <= highest_next;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> src/mpls_label_forwarding_table_unit.sv
// Top level of the MPLS label forwarding table: cell row plus sequencer.
//
// Commands arrive on the cmd channel, one beat per command, and each gives
// exactly one beat on the rsp channel. A command is taken while the block is
// idle, is resolved against every cell of the row in the next cycle (all
// cells compare their label and interface with the key at once, and the
// first hit wins), and the response beat is offered in the cycle after that.
// The next command is taken only once the response beat is gone, so the
// single shared sequencer works on one command at a time, and any time the
// receiver holds rsp.ready low delays the next command.
// Writes and removals happen in the resolving cycle: a removal shifts every
// cell above the hit down by one neighbor at once in that cycle, keeping order.
// Reset empties the table (all valid bits clear) and sets the highest label
// seen to zero; no clearing pass is needed. While the receiver stalls, the
// response is held and no new command is accepted.
module mpls_label_forwarding_table_unit
    import mlft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_OPS = MAX_OPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    mlft_cmd_if.sink   cmd,
    mlft_rsp_if.source rsp
);

    key_t                   key;
    entry_t                 write_entry;
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] hit_label;
    logic [TABLE_DEPTH-1:0] hit_lookup;
    logic [TABLE_DEPTH-1:0] write_en;
    logic [TABLE_DEPTH-1:0] shift_en;
    entry_t                 cell_entry [TABLE_DEPTH];

    mlft_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_OPS(MAX_OPS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .rsp(rsp),
        .key(key),
        .write_entry(write_entry),
        .cell_valid(cell_valid),
        .hit_label(hit_label),
        .hit_lookup(hit_lookup),
        .cell_entry(cell_entry),
        .write_en(write_en),
        .shift_en(shift_en)
    );

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic   up_valid;
        entry_t up_entry;
        if (g == TABLE_DEPTH - 1)
        begin : g_top
            assign up_valid = 1'b0;
            assign up_entry = cell_entry[g];
        end
        else
        begin : g_mid
            assign up_valid = cell_valid[g+1];
            assign up_entry = cell_entry[g+1];
        end

        mlft_cell u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .key(key),
            .write_en(write_en[g]),
            .write_entry(write_entry),
            .shift_en(shift_en[g]),
            .upper_valid(up_valid),
            .upper_entry(up_entry),
            .valid(cell_valid[g]),
            .entry(cell_entry[g]),
            .hit_label(hit_label[g]),
            .hit_lookup(hit_lookup[g])
        );
    end

endmodule

>>> bench/mpls_label_forwarding_table_unit_tb.sv
// Self-checking bench for the MPLS label table: directed rows, then random command traffic.
`timescale 1ns / 100ps

module mpls_label_forwarding_table_unit_tb;
    import mlft_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int NOPS = MAX_OPS_DEF;
    localparam int N_RANDOM = 680;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]           command;
        logic [IFACE_W-1:0]   in_iface;
        logic                 match_any_iface;
        logic [LABEL_W-1:0]   in_label;
        logic                 allocate_label;
        logic [IFACE_W-1:0]   out_iface;
        logic [COLOR_W-1:0]   color;
        logic [OPCNT_W-1:0]   op_count;
        logic [OPCODES_W-1:0] op_codes;
        logic [LABEL_W-1:0]   op0_label;
        logic [LABEL_W-1:0]   op1_label;
        logic [LABEL_W-1:0]   op2_label;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [LABEL_W-1:0]   result_label;
        logic [IFACE_W-1:0]   found_out_iface;
        logic [COLOR_W-1:0]   found_color;
        logic [OPCNT_W-1:0]   found_op_count;
        logic [OPCODES_W-1:0] found_op_codes;
        logic [LABEL_W-1:0]   found_op0_label;
        logic [LABEL_W-1:0]   found_op1_label;
        logic [LABEL_W-1:0]   found_op2_label;
    } rsp_beat_t;

    typedef struct {
        cmd_beat_t c;
        logic      has_rsp;
        rsp_beat_t r;
    } row_t;

    logic clk;
    logic rst_n;

    mlft_cmd_if cmd_ch();
    mlft_rsp_if rsp_ch();

    mpls_label_forwarding_table_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Shadow copy of the label table.
    logic                 lib_valid [DEPTH];
    entry_t               lib_entry [DEPTH];
    logic [LABEL_W-1:0]   lib_highest;

    rsp_beat_t expected_rsps[$];
    cmd_beat_t cmd_queue[$];
    int        mismatches;
    int        idle_cycles;
    logic      timed_out;
    logic      rsp_hold_request;
    logic      stall_active;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int lib_used();
        int n;
        n = 0;
        while (n < DEPTH && lib_valid[n])
            n++;
        return n;
    endfunction

    function automatic int lib_find(logic [LABEL_W-1:0] lab, logic chk, logic [IFACE_W-1:0] ifc);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!lib_valid[i])
                break;
            if (lib_entry[i].in_label == lab && (!chk || lib_entry[i].in_iface == ifc))
                return i;
        end
        return DEPTH;
    endfunction

    function automatic void lib_write(int i, logic [LABEL_W-1:0] lab, cmd_beat_t c);
        entry_t e;
        e = '0;
        e.in_label  = lab;
        e.in_iface  = c.in_iface;
        e.out_iface = c.out_iface;
        e.color     = c.color;
        e.op_count  = (c.op_count > NOPS) ? OPCNT_W'(NOPS) : c.op_count;
        e.op_codes  = c.op_codes;
        e.op0_label = c.op0_label;
        e.op1_label = c.op1_label;
        e.op2_label = c.op2_label;
        lib_valid[i] = 1'b1;
        lib_entry[i] = e;
    endfunction

    function automatic rsp_beat_t predict_lib_response(cmd_beat_t c);
        rsp_beat_t r;
        int i;
        int n;
        r = '0;
        r.status = ST_OK;
        r.result_label = c.in_label;
        case (cmd_t'(c.command))
            CMD_LOOKUP:
            begin
                i = lib_find(c.in_label, !c.match_any_iface, c.in_iface);
                if (i >= DEPTH)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found_out_iface = lib_entry[i].out_iface;
                    r.found_color     = lib_entry[i].color;
                    r.found_op_count  = lib_entry[i].op_count;
                    r.found_op_codes  = lib_entry[i].op_codes;
                    r.found_op0_label = lib_entry[i].op0_label;
                    r.found_op1_label = lib_entry[i].op1_label;
                    r.found_op2_label = lib_entry[i].op2_label;
                end
            end
            CMD_INSTALL:
            begin
                if (c.allocate_label)
                begin
                    n = lib_used();
                    if (lib_highest == LABEL_MAX)
                        r.status = ST_EXHAUSTED;
                    else if (n >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        lib_highest = lib_highest + 1'b1;
                        lib_write(n, lib_highest, c);
                        r.result_label = lib_highest;
                    end
                end
                else
                begin
                    i = lib_find(c.in_label, 1'b0, '0);
                    if (i >= DEPTH)
                        r.status = ST_NOT_FOUND;
                    else
                        lib_write(i, c.in_label, c);
                end
            end
            CMD_REMOVE:
            begin
                i = lib_find(c.in_label, 1'b0, '0);
                if (i >= DEPTH)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    n = lib_used();
                    for (int k = i; k + 1 < n; k++)
                        lib_entry[k] = lib_entry[k + 1];
                    if (n > 0)
                        lib_valid[n - 1] = 1'b0;
                end
            end
            default:
            begin
                n = lib_used();
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    lib_write(n, c.in_label, c);
                    if (c.in_label > lib_highest)
                        lib_highest = c.in_label;
                end
            end
        endcase
        return r;
    endfunction

    // Picks a label that is likely to hit an entry in the shadow table.
    function automatic logic [LABEL_W-1:0] pick_label();
        int n;
        n = lib_used();
        if (n > 0 && $urandom_range(0, 3) != 0)
            return lib_entry[$urandom_range(0, n - 1)].in_label;
        return ($urandom_range(0, 1) != 0) ? LABEL_W'($urandom_range(0, 40)) : LABEL_W'($urandom);
    endfunction

    function automatic cmd_beat_t random_cmd();
        cmd_beat_t    c;
        logic [191:0] raw;
        int n;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(cmd_beat_t)-1:0];
        n = lib_used();
        c.in_label = pick_label();
        if (n > 0 && $urandom_range(0, 1) != 0)
        begin
            // Half of the time, aim the interface at the entry with that label.
            int i;
            i = lib_find(c.in_label, 1'b0, '0);
            if (i < DEPTH)
                c.in_iface = lib_entry[i].in_iface;
        end
        // Keep the table churning: more appends when near empty, more removes when nearly full.
        if (n < 4 && $urandom_range(0, 1) != 0)
            c.command = ($urandom_range(0, 1) != 0) ? CMD_INSTALL : CMD_LOAD;
        else if (n >= DEPTH - 2 && $urandom_range(0, 1) != 0)
            c.command = CMD_REMOVE;
        if (c.command == CMD_LOAD && $urandom_range(0, 3) != 0)
            c.in_label = LABEL_W'($urandom_range(0, 5000));
        return c;
    endfunction

    // Accepted command beats feed the predictor in order of acceptance.
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            expected_rsps.insert(expected_rsps.size(),
                                 predict_lib_response(cmd_queue.pop_front()));
    end

    task automatic send_cmd(cmd_beat_t c);
        cmd_queue.insert(cmd_queue.size(), c);
        cmd_ch.valid           <= 1'b1;
        cmd_ch.command         <= c.command;
        cmd_ch.in_iface        <= c.in_iface;
        cmd_ch.match_any_iface <= c.match_any_iface;
        cmd_ch.in_label        <= c.in_label;
        cmd_ch.allocate_label  <= c.allocate_label;
        cmd_ch.out_iface       <= c.out_iface;
        cmd_ch.color           <= c.color;
        cmd_ch.op_count        <= c.op_count;
        cmd_ch.op_codes        <= c.op_codes;
        cmd_ch.op0_label       <= c.op0_label;
        cmd_ch.op1_label       <= c.op1_label;
        cmd_ch.op2_label       <= c.op2_label;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_with_gap(cmd_beat_t c, logic gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        send_cmd(c);
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (expected_rsps.size() != 0 || cmd_queue.size() != 0)
            @(posedge clk);
    endtask

    // Checks each response beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_beat_t got;
            rsp_beat_t exp;
            got = {rsp_ch.status, rsp_ch.result_label, rsp_ch.found_out_iface,
                   rsp_ch.found_color, rsp_ch.found_op_count, rsp_ch.found_op_codes,
                   rsp_ch.found_op0_label, rsp_ch.found_op1_label, rsp_ch.found_op2_label};
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response beat %h", got);
            end
            else
            begin
                exp = expected_rsps.pop_front();
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Response mismatch: expected %h, got %h (status %0d/%0d label %h/%h)",
                                 exp, got, exp.status, got.status, exp.result_label,
                                 got.result_label);
                end
            end
        end
    end

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int wait_cycles;
        rsp_ch.ready = 1'b0;
        stall_active = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rsp_hold_request)
            begin
                stall_active <= 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (60) @(posedge clk);
                stall_active <= 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic cmd_beat_t mk(cmd_t op, logic [LABEL_W-1:0] lab, logic alloc,
                                     logic [IFACE_W-1:0] ifc, logic any);
        cmd_beat_t c;
        c = '0;
        c.command = op;
        c.in_label = lab;
        c.allocate_label = alloc;
        c.in_iface = ifc;
        c.match_any_iface = any;
        return c;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t rw;
        cmd_beat_t c;
        rsp_beat_t r;

        mismatches = 0;
        rsp_hold_request = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.in_iface = '0;
        cmd_ch.match_any_iface = 1'b0;
        cmd_ch.in_label = '0;
        cmd_ch.allocate_label = 1'b0;
        cmd_ch.out_iface = '0;
        cmd_ch.color = '0;
        cmd_ch.op_count = '0;
        cmd_ch.op_codes = '0;
        cmd_ch.op0_label = '0;
        cmd_ch.op1_label = '0;
        cmd_ch.op2_label = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            lib_valid[i] = 1'b0;
            lib_entry[i] = '0;
        end
        lib_highest = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed responses only where they are plain.
        rw.c = mk(CMD_LOOKUP, '0, 0, '0, 1); rw.has_rsp = 1;
        rw.r = '0; rw.r.status = ST_NOT_FOUND; rows.insert(rows.size(), rw);
        rw.c = mk(CMD_REMOVE, 20'd5, 0, '0, 0); rw.has_rsp = 1;
        rw.r = '0; rw.r.status = ST_NOT_FOUND; rw.r.result_label = 20'd5;
        rows.insert(rows.size(), rw);
        rw.c = mk(CMD_INSTALL, 20'd9, 0, '0, 0); rw.has_rsp = 1;
        rw.r = '0; rw.r.status = ST_NOT_FOUND; rw.r.result_label = 20'd9;
        rows.insert(rows.size(), rw);
        // Allocate on an empty table: label one.
        rw.c = mk(CMD_INSTALL, 20'd77, 1, 4'hF, 0);
        rw.c.out_iface = 4'hF; rw.c.color = 16'hFFFF; rw.c.op_count = 2'd3;
        rw.c.op_codes = 6'h3F; rw.c.op0_label = '1; rw.c.op1_label = '1; rw.c.op2_label = '1;
        rw.has_rsp = 1; rw.r = '0; rw.r.result_label = 20'd1; rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'hF, 0); rw.has_rsp = 1;
        rw.r = '0; rw.r.result_label = 20'd1; rw.r.found_out_iface = 4'hF;
        rw.r.found_color = 16'hFFFF; rw.r.found_op_count = 2'd3; rw.r.found_op_codes = 6'h3F;
        rw.r.found_op0_label = '1; rw.r.found_op1_label = '1; rw.r.found_op2_label = '1;
        rows.insert(rows.size(), rw);
        rw.has_rsp = 0;
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'h0, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOAD, '0, 0, 4'h3, 0); rw.c.color = 16'h1234;
        rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOOKUP, '0, 0, 4'h3, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOAD, 20'd1, 0, 4'h2, 0); rw.c.color = 16'h0055;
        rows.insert(rows.size(), rw);
        // Duplicate label one: the first entry wins on an any-interface lookup.
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'h2, 1); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'h2, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_INSTALL, 20'd1, 0, 4'h6, 0); rw.c.op_count = 2'd2;
        rw.c.op_codes = 6'h2D; rw.c.op0_label = 20'hABCDE; rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'h6, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_REMOVE, 20'd1, 0, 4'h0, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_LOOKUP, 20'd1, 0, 4'h0, 1); rows.insert(rows.size(), rw);
        // Load the top label, then allocation is exhausted.
        rw.c = mk(CMD_LOAD, '1, 0, 4'h8, 0); rows.insert(rows.size(), rw);
        rw.c = mk(CMD_INSTALL, 20'd0, 1, 4'h0, 0); rw.has_rsp = 1;
        rw.r = '0; rw.r.status = ST_EXHAUSTED; rw.r.result_label = 20'd0;
        rows.insert(rows.size(), rw);
        rw.has_rsp = 0;
        rw.c = mk(CMD_REMOVE, '1, 0, 4'h0, 0); rows.insert(rows.size(), rw);
        for (int i = 0; i < rows.size(); i++)
        begin
            send_with_gap(rows[i].c, 1'b1);
            if (rows[i].has_rsp)
            begin
                // The predictor entry was pushed at acceptance; confirm it agrees.
                cmd_ch.valid <= 1'b0;
                @(negedge clk);
                if (expected_rsps[$] !== rows[i].r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Directed row %0d: typed %h, predicted %h",
                                 i, rows[i].r, expected_rsps[$]);
                end
            end
        end
        // Fill to a full table, then a load and an allocating install on the full table.
        wait_drained();
        while (lib_used() < DEPTH)
        begin
            c = random_cmd(); c.command = CMD_LOAD; c.in_label = LABEL_W'($urandom_range(0, 9));
            send_with_gap(c, 1'b0);
            wait_drained();
        end
        c = mk(CMD_LOAD, 20'd3, 0, 4'h1, 0); send_cmd(c);
        c = mk(CMD_INSTALL, 20'd3, 1, 4'h1, 0); send_cmd(c);
        cmd_ch.valid <= 1'b0;
        // Long receiver hold-off while the sender keeps offering.
        rsp_hold_request = 1'b1;
        wait (stall_active);
        rsp_hold_request = 1'b0;
        for (int k = 0; k < 6; k++)
            send_cmd(random_cmd());
        wait_drained();

        for (int k = 0; k < N_RANDOM; k++)
        begin
            c = random_cmd();
            send_with_gap(c, (k % 150) < 110);
            if (k == N_RANDOM / 2)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
src/mlft_pkg.sv
src/mlft_if.sv
src/mlft_cell.sv
src/mlft_ctrl.sv
src/mpls_label_forwarding_table_unit.sv
bench/mpls_label_forwarding_table_unit_tb.sv
